/* src/tcpd_pkg.sv */
// Shared types and codes for the two-class priority dispatcher.
package tcpd_pkg;

    // Operation carried in the input tuser.
    typedef enum logic [1:0] {
        OP_ADD_REGULAR = 2'd0,
        OP_ADD_URGENT  = 2'd1,
        OP_SERVE       = 2'd2,
        OP_REPORT      = 2'd3
    } opcode_t;

    // Result status carried in the output tuser.
    typedef enum logic [1:0] {
        STAT_OK     = 2'd0,
        STAT_EMPTY  = 2'd1,
        STAT_FULL   = 2'd2,
        STAT_REPORT = 2'd3
    } status_t;

    // What the finishing step has to report.
    typedef enum logic [2:0] {
        RK_OK,
        RK_EMPTY,
        RK_FULL,
        RK_REPORT,
        RK_URGENT,
        RK_REGULAR
    } result_kind_t;

    // Controller states.
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DECODE,
        ST_SCAN,
        ST_SCAN_TAIL,
        ST_SHIFT_INIT,
        ST_SHIFT,
        ST_FINISH
    } state_t;

    // Field widths.
    localparam int TAG_W     = 16;
    localparam int CASE_W    = 8;
    localparam int URG_W     = 4;
    localparam int MINUTE_W  = 11;
    localparam int WAIT_W    = 12;
    localparam int COUNT_W   = 5;
    localparam int S_TDATA_W = 40;
    localparam int S_TUSER_W = 2;
    localparam int M_TDATA_W = 64;
    localparam int M_TUSER_W = 3;

    // One urgent store entry.
    typedef struct packed {
        logic [TAG_W-1:0]    tag;
        logic [CASE_W-1:0]   code;
        logic [URG_W-1:0]    urg;
        logic [MINUTE_W-1:0] arrival;
    } urgent_entry_t;

    // One regular FIFO entry.
    typedef struct packed {
        logic [TAG_W-1:0]    tag;
        logic [MINUTE_W-1:0] arrival;
    } regular_entry_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic         load;
        logic         fifo_push;
        logic         fifo_pop;
        logic         heap_push;
        logic         scan_init;
        logic         scan_issue;
        logic         shift_init;
        logic         shift_issue;
        logic         heap_pop;
        logic         finish;
        result_kind_t kind;
    } cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        opcode_t op;
        logic    heap_empty;
        logic    heap_full;
        logic    fifo_empty;
        logic    fifo_full;
        logic    scan_last;
        logic    shift_done;
        logic    out_free;
    } sts_t;

endpackage

/* src/two_class_priority_dispatcher_top.sv */
// An add, a report or a regular serve passes through the decode and finish states before its
// result is loaded; an urgent serve first scans every waiting urgent entry, then moves each
// entry after the chosen one down one slot, then loads its result.
// One transaction is in work at a time and s_tready returns the cycle after the result is
// loaded; a result held by the sink delays the next one.
// Synchronous active-low reset empties both stores.
// Top level of the two-class priority dispatcher.
module two_class_priority_dispatcher_top #(
    parameter int HEAP_DEPTH = 16,
    parameter int FIFO_DEPTH = 16
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           s_tvalid,
    output logic                           s_tready,
    // client_tag[15:0], case_code[23:16], urgency[27:24], minute_now[38:28]
    input  logic [tcpd_pkg::S_TDATA_W-1:0] s_tdata,
    // opcode[1:0]
    input  logic [tcpd_pkg::S_TUSER_W-1:0] s_tuser,
    output logic                           m_tvalid,
    input  logic                           m_tready,
    // served_tag[15:0], served_case[23:16], served_urgency[27:24],
    // arrival_minute[38:28], wait_minutes[50:39], urgent_count[55:51],
    // regular_count[60:56]
    output logic [tcpd_pkg::M_TDATA_W-1:0] m_tdata,
    // status[1:0], served_urgent[2]
    output logic [tcpd_pkg::M_TUSER_W-1:0] m_tuser
);

    tcpd_pkg::cmd_t cmd;
    tcpd_pkg::sts_t sts;

    // Sequencer.
    tcpd_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .sts      (sts),
        .cmd      (cmd)
    );

    // Stores, search and result datapath.
    tcpd_datapath #(
        .HEAP_DEPTH (HEAP_DEPTH),
        .FIFO_DEPTH (FIFO_DEPTH)
    ) u_datapath (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .cmd      (cmd),
        .sts      (sts)
    );

endmodule

/* src/tcpd_ctrl.sv */
// Controller state machine that sequences decode, scan, shift and result steps.
module tcpd_ctrl (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             s_tvalid,
    output logic             s_tready,
    input  tcpd_pkg::sts_t   sts,
    output tcpd_pkg::cmd_t   cmd
);

    tcpd_pkg::state_t       state_reg, state_next;
    tcpd_pkg::result_kind_t kind_reg, kind_next;

    // State and pending result kind.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= tcpd_pkg::ST_IDLE;
            kind_reg  <= tcpd_pkg::RK_OK;
        end else begin
            state_reg <= state_next;
            kind_reg  <= kind_next;
        end
    end

    // Next state and commands.
    always_comb begin
        state_next = state_reg;
        kind_next  = kind_reg;
        cmd        = '0;
        cmd.kind   = kind_reg;
        s_tready   = 1'b0;
        unique case (state_reg)
            tcpd_pkg::ST_IDLE: begin
                s_tready = 1'b1;
                if (s_tvalid) begin
                    cmd.load   = 1'b1;
                    state_next = tcpd_pkg::ST_DECODE;
                end
            end
            tcpd_pkg::ST_DECODE: begin
                state_next = tcpd_pkg::ST_FINISH;
                unique case (sts.op)
                    tcpd_pkg::OP_ADD_REGULAR: begin
                        if (sts.fifo_full) begin
                            kind_next = tcpd_pkg::RK_FULL;
                        end else begin
                            cmd.fifo_push = 1'b1;
                            kind_next     = tcpd_pkg::RK_OK;
                        end
                    end
                    tcpd_pkg::OP_ADD_URGENT: begin
                        if (sts.heap_full) begin
                            kind_next = tcpd_pkg::RK_FULL;
                        end else begin
                            cmd.heap_push = 1'b1;
                            kind_next     = tcpd_pkg::RK_OK;
                        end
                    end
                    tcpd_pkg::OP_SERVE: begin
                        if (!sts.heap_empty) begin
                            cmd.scan_init = 1'b1;
                            kind_next     = tcpd_pkg::RK_URGENT;
                            state_next    = tcpd_pkg::ST_SCAN;
                        end else if (!sts.fifo_empty) begin
                            cmd.fifo_pop = 1'b1;
                            kind_next    = tcpd_pkg::RK_REGULAR;
                        end else begin
                            kind_next = tcpd_pkg::RK_EMPTY;
                        end
                    end
                    tcpd_pkg::OP_REPORT: begin
                        kind_next = tcpd_pkg::RK_REPORT;
                    end
                endcase
            end
            tcpd_pkg::ST_SCAN: begin
                cmd.scan_issue = 1'b1;
                if (sts.scan_last) begin
                    state_next = tcpd_pkg::ST_SCAN_TAIL;
                end
            end
            tcpd_pkg::ST_SCAN_TAIL: begin
                // The last compare lands in this cycle.
                state_next = tcpd_pkg::ST_SHIFT_INIT;
            end
            tcpd_pkg::ST_SHIFT_INIT: begin
                cmd.shift_init = 1'b1;
                state_next     = tcpd_pkg::ST_SHIFT;
            end
            tcpd_pkg::ST_SHIFT: begin
                if (sts.shift_done) begin
                    cmd.heap_pop = 1'b1;
                    state_next   = tcpd_pkg::ST_FINISH;
                end else begin
                    cmd.shift_issue = 1'b1;
                end
            end
            tcpd_pkg::ST_FINISH: begin
                if (sts.out_free) begin
                    cmd.finish = 1'b1;
                    state_next = tcpd_pkg::ST_IDLE;
                end
            end
            default: begin
                state_next = tcpd_pkg::ST_IDLE;
            end
        endcase
    end

endmodule

/* src/tcpd_datapath.sv */
// Datapath: urgent and regular stores, scan and shift logic, output register.
module tcpd_datapath #(
    parameter int HEAP_DEPTH = 16,
    parameter int FIFO_DEPTH = 16
) (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic [tcpd_pkg::S_TDATA_W-1:0]     s_tdata,
    input  logic [tcpd_pkg::S_TUSER_W-1:0]     s_tuser,
    output logic                               m_tvalid,
    input  logic                               m_tready,
    output logic [tcpd_pkg::M_TDATA_W-1:0]     m_tdata,
    output logic [tcpd_pkg::M_TUSER_W-1:0]     m_tuser,
    input  tcpd_pkg::cmd_t                     cmd,
    output tcpd_pkg::sts_t                     sts
);

    localparam int HAW = (HEAP_DEPTH > 1) ? $clog2(HEAP_DEPTH) : 1;
    localparam int HCW = $clog2(HEAP_DEPTH + 1);
    localparam int FAW = (FIFO_DEPTH > 1) ? $clog2(FIFO_DEPTH) : 1;
    localparam int FCW = $clog2(FIFO_DEPTH + 1);

    // Latched input transaction.
    tcpd_pkg::opcode_t                 in_op_reg;
    logic [tcpd_pkg::TAG_W-1:0]        in_tag_reg;
    logic [tcpd_pkg::CASE_W-1:0]       in_code_reg;
    logic [tcpd_pkg::URG_W-1:0]        in_urg_reg;
    logic [tcpd_pkg::MINUTE_W-1:0]     in_now_reg;

    // Stores and their bookkeeping.
    tcpd_pkg::urgent_entry_t  heap_mem [HEAP_DEPTH];
    tcpd_pkg::regular_entry_t fifo_mem [FIFO_DEPTH];
    tcpd_pkg::urgent_entry_t  heap_rdata_reg;
    tcpd_pkg::regular_entry_t fifo_rdata_reg;
    logic [HCW-1:0]           heap_size_reg;
    logic [FAW-1:0]           fifo_head_reg;
    logic [FAW-1:0]           fifo_tail_reg;
    logic [FCW-1:0]           fifo_size_reg;

    // Scan and shift sequencing.
    logic [HCW-1:0]           scan_idx_reg;
    logic                     cmp_valid_reg;
    logic [HAW-1:0]           cmp_pos_reg;
    tcpd_pkg::urgent_entry_t  best_reg;
    logic [HAW-1:0]           best_idx_reg;
    logic [HCW-1:0]           sh_idx_reg;
    logic                     mv_valid_reg;
    logic [HCW-1:0]           mv_pos_reg;

    // Output register.
    logic                             m_tvalid_reg;
    logic [tcpd_pkg::M_TDATA_W-1:0]   m_tdata_reg;
    logic [tcpd_pkg::M_TUSER_W-1:0]   m_tuser_reg;

    logic                     heap_we;
    logic [HAW-1:0]           heap_waddr;
    tcpd_pkg::urgent_entry_t  heap_wdata;
    logic [HAW-1:0]           heap_raddr;
    logic                     heap_re;
    logic [HCW-1:0]           mv_wpos;
    logic [HCW+4:0]           heap_cnt_ext;
    logic [FCW+4:0]           fifo_cnt_ext;
    logic [FAW-1:0]           fifo_tail_next;
    logic [FAW-1:0]           fifo_head_next;
    logic [tcpd_pkg::M_TDATA_W-1:0] m_tdata_next;
    logic [tcpd_pkg::M_TUSER_W-1:0] m_tuser_next;

    // Status toward the controller.
    always_comb begin
        sts.op         = in_op_reg;
        sts.heap_empty = (heap_size_reg == '0);
        sts.heap_full  = (heap_size_reg >= HCW'(HEAP_DEPTH));
        sts.fifo_empty = (fifo_size_reg == '0);
        sts.fifo_full  = (fifo_size_reg >= FCW'(FIFO_DEPTH));
        sts.scan_last  = ((scan_idx_reg + HCW'(1)) == heap_size_reg);
        sts.shift_done = (sh_idx_reg >= heap_size_reg);
        sts.out_free   = !m_tvalid_reg || m_tready;
    end

    // Input latch.
    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            in_op_reg   <= tcpd_pkg::opcode_t'(s_tuser[1:0]);
            in_tag_reg  <= s_tdata[15:0];
            in_code_reg <= s_tdata[23:16];
            in_urg_reg  <= s_tdata[27:24];
            in_now_reg  <= s_tdata[38:28];
        end
    end

    // Urgent store ports: append at the end, or move an entry down one slot.
    assign mv_wpos = mv_pos_reg - HCW'(1);
    always_comb begin
        heap_we    = cmd.heap_push || mv_valid_reg;
        heap_re    = cmd.scan_issue || cmd.shift_issue;
        heap_raddr = cmd.scan_issue ? scan_idx_reg[HAW-1:0] : sh_idx_reg[HAW-1:0];
        if (cmd.heap_push) begin
            heap_waddr = heap_size_reg[HAW-1:0];
            heap_wdata = '{tag: in_tag_reg, code: in_code_reg,
                           urg: in_urg_reg, arrival: in_now_reg};
        end else begin
            heap_waddr = mv_wpos[HAW-1:0];
            heap_wdata = heap_rdata_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (heap_we) begin
            heap_mem[heap_waddr] <= heap_wdata;
        end
        if (heap_re) begin
            heap_rdata_reg <= heap_mem[heap_raddr];
        end
    end

    // Regular FIFO memory.
    always_ff @(posedge aclk) begin
        if (cmd.fifo_push) begin
            fifo_mem[fifo_tail_reg] <= '{tag: in_tag_reg, arrival: in_now_reg};
        end
        if (cmd.fifo_pop) begin
            fifo_rdata_reg <= fifo_mem[fifo_head_reg];
        end
    end

    // FIFO pointer wrap.
    assign fifo_tail_next = (fifo_tail_reg == FAW'(FIFO_DEPTH - 1)) ? '0
                          : fifo_tail_reg + FAW'(1);
    assign fifo_head_next = (fifo_head_reg == FAW'(FIFO_DEPTH - 1)) ? '0
                          : fifo_head_reg + FAW'(1);

    // Store sizes and FIFO pointers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            heap_size_reg <= '0;
            fifo_head_reg <= '0;
            fifo_tail_reg <= '0;
            fifo_size_reg <= '0;
        end else begin
            if (cmd.heap_push) begin
                heap_size_reg <= heap_size_reg + HCW'(1);
            end else if (cmd.heap_pop) begin
                heap_size_reg <= heap_size_reg - HCW'(1);
            end
            if (cmd.fifo_push) begin
                fifo_tail_reg <= fifo_tail_next;
                fifo_size_reg <= fifo_size_reg + FCW'(1);
            end else if (cmd.fifo_pop) begin
                fifo_head_reg <= fifo_head_next;
                fifo_size_reg <= fifo_size_reg - FCW'(1);
            end
        end
    end

    // Scan and shift pipeline flags.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cmp_valid_reg <= 1'b0;
            mv_valid_reg  <= 1'b0;
        end else begin
            cmp_valid_reg <= cmd.scan_issue;
            mv_valid_reg  <= cmd.shift_issue;
        end
    end

    // Scan for the first entry of the largest urgency. The store is kept in
    // insertion order, so a strict compare gives ties to the oldest entry.
    always_ff @(posedge aclk) begin
        if (cmd.scan_init) begin
            scan_idx_reg <= '0;
        end else if (cmd.scan_issue) begin
            scan_idx_reg <= scan_idx_reg + HCW'(1);
        end
        if (cmd.scan_issue) begin
            cmp_pos_reg <= scan_idx_reg[HAW-1:0];
        end
        if (cmp_valid_reg &&
            ((cmp_pos_reg == '0) || (heap_rdata_reg.urg > best_reg.urg))) begin
            best_reg     <= heap_rdata_reg;
            best_idx_reg <= cmp_pos_reg;
        end
    end

    // Close the gap: each entry after the chosen one moves down one slot.
    always_ff @(posedge aclk) begin
        if (cmd.shift_init) begin
            sh_idx_reg <= HCW'(best_idx_reg) + HCW'(1);
        end else if (cmd.shift_issue) begin
            sh_idx_reg <= sh_idx_reg + HCW'(1);
        end
        if (cmd.shift_issue) begin
            mv_pos_reg <= sh_idx_reg;
        end
    end

    // Result assembly.
    assign heap_cnt_ext = {5'd0, heap_size_reg};
    assign fifo_cnt_ext = {5'd0, fifo_size_reg};

    always_comb begin
        logic [tcpd_pkg::TAG_W-1:0]    srv_tag;
        logic [tcpd_pkg::CASE_W-1:0]   srv_code;
        logic [tcpd_pkg::URG_W-1:0]    srv_urg;
        logic [tcpd_pkg::MINUTE_W-1:0] srv_arr;
        logic [tcpd_pkg::WAIT_W-1:0]   srv_wait;
        logic                          srv_urgent;
        tcpd_pkg::status_t             stat;
        srv_tag    = '0;
        srv_code   = '0;
        srv_urg    = '0;
        srv_arr    = '0;
        srv_wait   = '0;
        srv_urgent = 1'b0;
        stat       = tcpd_pkg::STAT_OK;
        unique case (cmd.kind)
            tcpd_pkg::RK_OK:     stat = tcpd_pkg::STAT_OK;
            tcpd_pkg::RK_EMPTY:  stat = tcpd_pkg::STAT_EMPTY;
            tcpd_pkg::RK_FULL:   stat = tcpd_pkg::STAT_FULL;
            tcpd_pkg::RK_REPORT: stat = tcpd_pkg::STAT_REPORT;
            tcpd_pkg::RK_URGENT: begin
                srv_urgent = 1'b1;
                srv_tag    = best_reg.tag;
                srv_code   = best_reg.code;
                srv_urg    = best_reg.urg;
                srv_arr    = best_reg.arrival;
                srv_wait   = {1'b0, in_now_reg} - {1'b0, best_reg.arrival};
            end
            tcpd_pkg::RK_REGULAR: begin
                srv_tag  = fifo_rdata_reg.tag;
                srv_arr  = fifo_rdata_reg.arrival;
                srv_wait = {1'b0, in_now_reg} - {1'b0, fifo_rdata_reg.arrival};
            end
            default: stat = tcpd_pkg::STAT_OK;
        endcase
        m_tdata_next = {3'd0, fifo_cnt_ext[4:0], heap_cnt_ext[4:0], srv_wait,
                        srv_arr, srv_urg, srv_code, srv_tag};
        m_tuser_next = {srv_urgent, stat};
    end

    // Output register; the next transaction may be taken while it waits.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (cmd.finish) begin
            m_tvalid_reg <= 1'b1;
        end else if (m_tready) begin
            m_tvalid_reg <= 1'b0;
        end
        if (cmd.finish) begin
            m_tdata_reg <= m_tdata_next;
            m_tuser_reg <= m_tuser_next;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;

    // Sizes never exceed the store depths.
    a_heap_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        heap_size_reg <= HCW'(HEAP_DEPTH))
        else $error("urgent store size beyond depth");

    a_fifo_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        fifo_size_reg <= FCW'(FIFO_DEPTH))
        else $error("regular FIFO size beyond depth");

    // An append and an entry move never share the urgent store write port.
    a_heap_wport: assert property (@(posedge aclk) disable iff (!aresetn)
        !(cmd.heap_push && mv_valid_reg))
        else $error("urgent store write port conflict");

    // Empty or full FIFO has its pointers together.
    a_fifo_ptrs: assert property (@(posedge aclk) disable iff (!aresetn)
        (fifo_size_reg == '0 || fifo_size_reg == FCW'(FIFO_DEPTH))
        |-> (fifo_head_reg == fifo_tail_reg))
        else $error("FIFO pointers disagree with size");

endmodule
